// ===== hw/rtl/sob_pkg.sv =====
// Package for the Sobel edge magnitude block: widths, register map,
// reset values, controller states and the lane control struct.
// No dependencies; every other file of the block imports it.
package sob_pkg;

    // Pixel and channel widths.
    localparam int PIX_W = 8;
    localparam int RGB_W = 3 * PIX_W;
    localparam int LANES = 3;

    // Configuration register map (APB data 32 bits, registers at 4*i).
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int WIDTH_REG_W = 11;
    localparam int HEIGHT_REG_W = 13;
    localparam logic REG_IMAGE_WIDTH = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;
    localparam logic [WIDTH_REG_W-1:0] WIDTH_RESET = 11'd640;
    localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd480;

    // Input item kinds.
    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    // Lane arithmetic: gradients, sum of squares and rounded root.
    localparam int SUM_W = PIX_W + 2;
    localparam int GRAD_W = PIX_W + 3;
    localparam int SQ_W = 2 * GRAD_W;
    localparam int ROOT_W = 17;
    localparam int ROOT_STEPS = 8;
    localparam logic [SQ_W-1:0] SAT_LIMIT = 22'd65280;
    localparam logic [PIX_W-1:0] SAT_MAG = 8'd255;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_GRAD,
        ST_SQUARE,
        ST_ROOT,
        ST_DONE
    } sob_state_t;

    // Control from the sequencer to the channel lanes.
    typedef struct packed {
        logic       grad_en;
        logic       square_en;
        logic       root_en;
        logic [2:0] step;
    } sob_lane_ctrl_t;

endpackage

// ===== hw/rtl/sob_if.sv =====
// Stream channel interfaces for the Sobel block: pixel items in, magnitude
// items out. Depends on sob_pkg for field widths.
interface sob_pixel_if;
    import sob_pkg::*;

    logic             valid;
    logic             ready;
    logic             kind;
    logic [PIX_W-1:0] in_red;
    logic [PIX_W-1:0] in_green;
    logic [PIX_W-1:0] in_blue;

    modport source (output valid, kind, in_red, in_green, in_blue, input ready);
    modport sink (input valid, kind, in_red, in_green, in_blue, output ready);
endinterface

interface sob_result_if;
    import sob_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] out_red;
    logic [PIX_W-1:0] out_green;
    logic [PIX_W-1:0] out_blue;
    logic             frame_last;

    modport source (output valid, out_red, out_green, out_blue, frame_last, input ready);
    modport sink (input valid, out_red, out_green, out_blue, frame_last, output ready);
endinterface

// ===== hw/rtl/sobel_edge_magnitude_rgb.sv =====
// Top level of the RGB Sobel edge magnitude block: APB registers, line
// stores, 3x3 window, sequencer, three channel lanes and the output register.
// Depends on sob_pkg, sob_if, sob_line_buf and sob_lane.
//
// Usage: pixels of a frame enter in raster order on the pixel channel
// (valid/ready, kind = 0); after the last pixel, image_width + 1 items of
// any kind drain the tail. Results leave on the result channel one row plus
// one pixel behind the input; the result of the frame's last pixel has
// frame_last set, after which the next item starts a new frame. Flush items
// that arrive before the frame's pixels are all in are dropped.
// An item that gives a result passes through the load, gradient, square,
// root and done states before the next item is accepted; the root state runs
// the 8-step square root iteration in the lanes. An item that gives no result
// passes only through load. image_width and image_height are to be written
// over APB only while the block is idle; the block does not enforce this. A
// write restarts the frame. Reset sets 640 x 480 and clears the window and
// position counters; the line stores are not cleared. When the receiver
// stalls, the finished result waits in the output register while the next
// item is already taken and processed up to the point of handing over.
module sobel_edge_magnitude_rgb #(
    parameter int MAX_WIDTH = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                             clk,
    input  logic                             rst_n,
    sob_pixel_if.sink                        pixel,
    sob_result_if.source                     result,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [sob_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [sob_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [sob_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);
    import sob_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int ROW_W = $clog2(MAX_HEIGHT + 2);

    sob_state_t state_reg;
    sob_state_t state_next;

    logic [WIDTH_REG_W-1:0]  width_reg;
    logic [HEIGHT_REG_W-1:0] height_reg;
    logic                    cfg_we;
    logic [WW-1:0]           eff_w;
    logic [HW-1:0]           eff_h;

    logic [COL_W-1:0]        col_reg;
    logic [ROW_W-1:0]        row_reg;
    logic [COL_W-1:0]        col_next;
    logic [ROW_W-1:0]        row_next;
    logic [WW-1:0]           col_inc;
    logic [2:0][2:0][RGB_W-1:0] window_reg;
    logic [RGB_W-1:0]        pix_reg;
    logic [2:0]              rv_reg;
    logic [2:0]              cv_reg;
    logic                    last_reg;
    logic [2:0]              rv_next;
    logic [2:0]              cv_next;
    logic                    last_next;

    logic                    pixels_done;
    logic                    accept;
    logic                    take;
    logic                    emit;
    logic [ROW_W-1:0]        orow;
    logic [WW-1:0]           ocol;
    logic [2:0]              root_step_reg;
    logic                    restart;

    logic                    mem_rd_en;
    logic                    mem_wr_en;
    logic [2*RGB_W-1:0]      mem_rd_data;
    logic [RGB_W-1:0]        top_px;
    logic [RGB_W-1:0]        mid_px;

    sob_lane_ctrl_t          lane_ctrl;
    logic [LANES-1:0][PIX_W-1:0] lane_mag;
    logic                    out_free;
    logic                    out_load;
    logic                    out_valid_reg;
    logic [PIX_W-1:0]        out_red_reg;
    logic [PIX_W-1:0]        out_green_reg;
    logic [PIX_W-1:0]        out_blue_reg;
    logic                    out_last_reg;

    // APB register port; writes complete in the access phase.
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_IMAGE_HEIGHT) ?
                    APB_DATA_W'(height_reg) : APB_DATA_W'(width_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            case (paddr[2])
                REG_IMAGE_WIDTH:  width_reg  <= pwdata[WIDTH_REG_W-1:0];
                REG_IMAGE_HEIGHT: height_reg <= pwdata[HEIGHT_REG_W-1:0];
                default:          width_reg  <= width_reg;
            endcase
        end
    end

    // Effective frame size: zero counts as one, large values saturate.
    always_comb
    begin
        if (width_reg == '0)
            eff_w = WW'(1);
        else if (32'(width_reg) > 32'(MAX_WIDTH))
            eff_w = WW'(MAX_WIDTH);
        else
            eff_w = WW'(width_reg);

        if (height_reg == '0)
            eff_h = HW'(1);
        else if (32'(height_reg) > 32'(MAX_HEIGHT))
            eff_h = HW'(MAX_HEIGHT);
        else
            eff_h = HW'(height_reg);
    end

    // Input acceptance; early flush items are dropped without effect.
    assign pixels_done = row_reg >= ROW_W'(eff_h);
    assign accept = pixel.valid && pixel.ready;
    assign take = accept && ((pixel.kind == KIND_PIXEL) || pixels_done);

    // Line stores, read at the current column.
    sob_line_buf #(
        .DEPTH (MAX_WIDTH),
        .AW    (COL_W)
    ) u_line_buf (
        .clk     (clk),
        .rd_en   (mem_rd_en),
        .wr_en   (mem_wr_en),
        .addr    (col_reg),
        .wr_data ({mid_px, pix_reg}),
        .rd_data (mem_rd_data)
    );

    assign top_px = mem_rd_data[2*RGB_W-1:RGB_W];
    assign mid_px = mem_rd_data[RGB_W-1:0];

    // Position of the window center and its frame-edge masks.
    always_comb
    begin
        col_inc = WW'(col_reg) + WW'(1);
        if (col_reg != '0)
        begin
            emit = row_reg >= ROW_W'(1);
            orow = row_reg - ROW_W'(1);
            ocol = WW'(col_reg) - WW'(1);
        end
        else
        begin
            emit = row_reg >= ROW_W'(2);
            orow = row_reg - ROW_W'(2);
            ocol = eff_w - WW'(1);
        end
        emit = emit && (orow < ROW_W'(eff_h));

        if (col_inc >= eff_w)
        begin
            col_next = '0;
            row_next = row_reg + ROW_W'(1);
        end
        else
        begin
            col_next = col_inc[COL_W-1:0];
            row_next = row_reg;
        end

        rv_next   = {(orow + ROW_W'(1)) < ROW_W'(eff_h), 1'b1, orow != '0};
        cv_next   = {(ocol + WW'(1)) < eff_w, 1'b1, ocol != '0};
        last_next = ((orow + ROW_W'(1)) == ROW_W'(eff_h)) &&
                    ((ocol + WW'(1)) == eff_w);
    end

    // A config write or the frame's last result restarts the frame.
    assign restart = cfg_we || ((state_reg == ST_GRAD) && last_reg);

    // Position counters, window and sequencer state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            col_reg       <= '0;
            row_reg       <= '0;
            window_reg    <= '0;
            root_step_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (restart)
            begin
                col_reg    <= '0;
                row_reg    <= '0;
                window_reg <= '0;
            end
            else if (state_reg == ST_LOAD)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
                for (int i = 0; i < 3; i++)
                begin
                    window_reg[i][0] <= window_reg[i][1];
                    window_reg[i][1] <= window_reg[i][2];
                end
                window_reg[0][2] <= top_px;
                window_reg[1][2] <= mid_px;
                window_reg[2][2] <= pix_reg;
            end

            if (state_reg == ST_ROOT)
                root_step_reg <= root_step_reg + 3'd1;
            else
                root_step_reg <= '0;
        end
    end

    // Item payload and result position flags.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            pix_reg <= pixels_done ? '0 : {pixel.in_red, pixel.in_green, pixel.in_blue};
        end
        if (state_reg == ST_LOAD)
        begin
            rv_reg   <= rv_next;
            cv_reg   <= cv_next;
            last_reg <= last_next;
        end
    end

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (take) state_next = ST_LOAD;
            ST_LOAD:   state_next = emit ? ST_GRAD : ST_IDLE;
            ST_GRAD:   state_next = ST_SQUARE;
            ST_SQUARE: state_next = ST_ROOT;
            ST_ROOT:   if (root_step_reg == 3'(ROOT_STEPS - 1)) state_next = ST_DONE;
            ST_DONE:   if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        pixel.ready         = 1'b0;
        mem_rd_en           = 1'b0;
        mem_wr_en           = 1'b0;
        lane_ctrl.grad_en   = 1'b0;
        lane_ctrl.square_en = 1'b0;
        lane_ctrl.root_en   = 1'b0;
        lane_ctrl.step      = root_step_reg;
        out_load            = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                pixel.ready = 1'b1;
                mem_rd_en   = take;
            end
            ST_LOAD:   mem_wr_en = 1'b1;
            ST_GRAD:   lane_ctrl.grad_en = 1'b1;
            ST_SQUARE: lane_ctrl.square_en = 1'b1;
            ST_ROOT:   lane_ctrl.root_en = 1'b1;
            ST_DONE:   out_load = out_free;
            default:   pixel.ready = 1'b0;
        endcase
    end

    // One lane per channel, all driven by the same sequencer.
    for (genvar k = 0; k < LANES; k++)
    begin : g_lane
        logic [2:0][2:0][PIX_W-1:0] lane_win;

        always_comb
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    lane_win[i][j] = window_reg[i][j][(LANES-1-k)*PIX_W +: PIX_W];
                end
            end
        end

        sob_lane u_lane (
            .clk      (clk),
            .ctrl     (lane_ctrl),
            .win      (lane_win),
            .row_mask (rv_reg),
            .col_mask (cv_reg),
            .mag      (lane_mag[k])
        );
    end

    // Merge the lane results into the output register.
    assign out_free = !out_valid_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_red_reg   <= lane_mag[0];
            out_green_reg <= lane_mag[1];
            out_blue_reg  <= lane_mag[2];
            out_last_reg  <= last_reg;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.out_red    = out_red_reg;
    assign result.out_green  = out_green_reg;
    assign result.out_blue   = out_blue_reg;
    assign result.frame_last = out_last_reg;

endmodule

// ===== hw/rtl/sob_line_buf.sv =====
// Line store memory: each entry holds the upper and the middle line pixel
// of one column. Registered read, single address. Uses sob_pkg widths.
module sob_line_buf #(
    parameter int DEPTH = 1024,
    parameter int AW = 10
) (
    input  logic                         clk,
    input  logic                         rd_en,
    input  logic                         wr_en,
    input  logic [AW-1:0]                addr,
    input  logic [2*sob_pkg::RGB_W-1:0]  wr_data,
    output logic [2*sob_pkg::RGB_W-1:0]  rd_data
);
    import sob_pkg::*;

    logic [2*RGB_W-1:0] line_ram_reg [DEPTH];
    logic [2*RGB_W-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            line_ram_reg[addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= line_ram_reg[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/sob_lane.sv =====
// One channel lane: masked 3x3 Sobel gradients, sum of squares and a
// bit-by-bit rounded square root saturated at 255. Uses sob_pkg.
module sob_lane (
    input  logic                                   clk,
    input  sob_pkg::sob_lane_ctrl_t                ctrl,
    input  logic [2:0][2:0][sob_pkg::PIX_W-1:0]    win,
    input  logic [2:0]                             row_mask,
    input  logic [2:0]                             col_mask,
    output logic [sob_pkg::PIX_W-1:0]              mag
);
    import sob_pkg::*;

    logic [2:0][2:0][PIX_W-1:0] px;
    logic [SUM_W-1:0]           sum_left;
    logic [SUM_W-1:0]           sum_right;
    logic [SUM_W-1:0]           sum_top;
    logic [SUM_W-1:0]           sum_bottom;
    logic signed [GRAD_W-1:0]   gx_next;
    logic signed [GRAD_W-1:0]   gy_next;
    logic signed [GRAD_W-1:0]   gx_reg;
    logic signed [GRAD_W-1:0]   gy_reg;
    logic signed [SQ_W-1:0]     gx_sq;
    logic signed [SQ_W-1:0]     gy_sq;
    logic [SQ_W-1:0]            n_sum;
    logic                       sat_reg;
    logic [ROOT_W-1:0]          m_reg;
    logic [ROOT_W-1:0]          res_reg;
    logic [ROOT_W-1:0]          bit_val;
    logic [ROOT_W-1:0]          trial;
    logic [PIX_W-1:0]           res_low;

    // Neighbors outside the frame count as zero.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                px[i][j] = (row_mask[i] && col_mask[j]) ? win[i][j] : '0;
            end
        end
    end

    // Weighted column and row sums of the two kernels.
    always_comb
    begin
        sum_left   = SUM_W'(px[0][0]) + {1'b0, px[1][0], 1'b0} + SUM_W'(px[2][0]);
        sum_right  = SUM_W'(px[0][2]) + {1'b0, px[1][2], 1'b0} + SUM_W'(px[2][2]);
        sum_top    = SUM_W'(px[0][0]) + {1'b0, px[0][1], 1'b0} + SUM_W'(px[0][2]);
        sum_bottom = SUM_W'(px[2][0]) + {1'b0, px[2][1], 1'b0} + SUM_W'(px[2][2]);
        gx_next    = $signed({1'b0, sum_right}) - $signed({1'b0, sum_left});
        gy_next    = $signed({1'b0, sum_bottom}) - $signed({1'b0, sum_top});
    end

    // Squared magnitude, at most 2 * 1020 * 1020, fits unsigned.
    always_comb
    begin
        gx_sq = SQ_W'(gx_reg) * SQ_W'(gx_reg);
        gy_sq = SQ_W'(gy_reg) * SQ_W'(gy_reg);
        n_sum = $unsigned(gx_sq) + $unsigned(gy_sq);
    end

    // One root digit per step, from bit 14 down to bit 0.
    always_comb
    begin
        bit_val = ROOT_W'(1) << (4'd14 - {ctrl.step, 1'b0});
        trial   = res_reg + bit_val;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.grad_en)
        begin
            gx_reg <= gx_next;
            gy_reg <= gy_next;
        end
        if (ctrl.square_en)
        begin
            sat_reg <= n_sum > SAT_LIMIT;
            m_reg   <= ROOT_W'(n_sum[15:0]);
            res_reg <= '0;
        end
        else if (ctrl.root_en)
        begin
            if (m_reg >= trial)
            begin
                m_reg   <= m_reg - trial;
                res_reg <= (res_reg >> 1) + bit_val;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
        end
    end

    // Round up when the remainder exceeds the root.
    assign res_low = res_reg[PIX_W-1:0];
    assign mag = sat_reg ? SAT_MAG : ((m_reg > res_reg) ? res_low + PIX_W'(1) : res_low);

endmodule
